// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the PPM P6 byte stream parser.
// Used by every module under rtl/core; depends on nothing else.
package pps_pkg;

  // Parser phase, one value per region of the file.
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_COMMENT = 3'd2,
    PH_TAIL    = 3'd3,
    PH_RASTER  = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_RASTER    = 2'd1;
  localparam logic [1:0] KIND_TRUNCATED = 2'd2;

  // Character codes seen in the header.
  localparam logic [7:0] CHR_HASH    = 8'h23;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;

  // Channel indices.
  localparam logic [1:0] CHAN_RED  = 2'd0;
  localparam logic [1:0] CHAN_BLUE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_level;
    logic [7:0]  pixel_byte;
    logic [1:0]  channel;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/core/ppm_p6_stream_parser.sv -----
// Top level of the PPM P6 byte stream parser.
// Depends on pps_pkg, pps_dim_mult, pps_parse and pps_out_buf.
//
//   Port group        Direction  Handshake               Moves
//   in_*              in         in_valid_i / in_stall_o  one file byte item
//   out_*             out        out_valid_o / out_stall_i one result item
//
// One byte item is accepted in every cycle in which in_valid_i is high and
// in_stall_o is low; its result, if any, goes into the output register, or
// into the skid entry while the output register is held. The sustained
// rate is one item per cycle while in_stall_o stays low.
// rst_ni clears all parser state asynchronously; a start_of_file mark on an
// item clears it as well before that byte is parsed.
// in_stall_o rises only when both the output register and the skid entry
// hold results, that is once out_stall_i holds back the output register
// while another result arrives, and it falls in the cycle after the output register is taken.
//
// The raster byte count width*height*3 comes from a registered multiplier that
// tracks the stored width and height; the height is always stored at least
// two items before the header result, so the product is always current.
module ppm_p6_stream_parser
  import pps_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic                  accept;
  logic                  buf_full;
  logic                  res_valid;
  out_item_t             res;
  logic [DIM_BITS-1:0]   width;
  logic [DIM_BITS-1:0]   height;
  logic [2*DIM_BITS-1:0] prod;

  // The stall is registered state of the buffer, never a path from out_stall_i.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  pps_dim_mult #(
    .DIM_BITS (DIM_BITS)
  ) u_dim_mult (
    .clk_i    (clk_i),
    .width_i  (width),
    .height_i (height),
    .prod_o   (prod)
  );

  pps_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .prod_i      (prod),
    .width_o     (width),
    .height_o    (height),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/pps_dim_mult.sv -----
// Registered width times height product for the raster byte count.
// Depends on pps_pkg only for the project convention of a shared import.
module pps_dim_mult
  import pps_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [DIM_BITS-1:0]   width_i,
  input  logic [DIM_BITS-1:0]   height_i,
  output logic [2*DIM_BITS-1:0] prod_o
);

  logic [2*DIM_BITS-1:0] prod_q;
  logic [2*DIM_BITS-1:0] prod_d;

  // Height is always stored at least two items before the header result is
  // due, so the registered product is always current when it is used.
  assign prod_d = (2*DIM_BITS)'(width_i) * (2*DIM_BITS)'(height_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/core/pps_parse.sv -----
// Header scanner and raster counter: all parser state and the result of
// each accepted item. Depends on pps_pkg and on the product from pps_dim_mult.
module pps_parse
  import pps_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  in_item_t              item_i,
  input  logic [2*DIM_BITS-1:0] prod_i,
  output logic [DIM_BITS-1:0]   width_o,
  output logic [DIM_BITS-1:0]   height_o,
  output logic                  res_valid_o,
  output out_item_t             res_o
);

  localparam int LeftBits = 2*DIM_BITS + 2;

  phase_e                phase_q, phase_d;
  logic                  magic_q, magic_d;
  logic [DIM_BITS-1:0]   acc_q, acc_d;
  logic                  in_num_q, in_num_d;
  logic [1:0]            fields_q, fields_d;
  logic [DIM_BITS-1:0]   width_q, width_d;
  logic [DIM_BITS-1:0]   height_q, height_d;
  logic [DIM_BITS-1:0]   maxval_q, maxval_d;
  logic [LeftBits-1:0]   left_q, left_d;
  logic [1:0]            chan_q, chan_d;

  // Current state as seen by this item: a start mark clears it first.
  phase_e                ph_c;
  logic                  magic_c;
  logic [DIM_BITS-1:0]   acc_c;
  logic                  in_num_c;
  logic [1:0]            fields_c;
  logic [DIM_BITS-1:0]   width_c;
  logic [DIM_BITS-1:0]   height_c;
  logic [DIM_BITS-1:0]   maxval_c;
  logic [LeftBits-1:0]   left_c;
  logic [1:0]            chan_c;

  logic [7:0]            b;
  logic                  is_digit;
  logic                  was_max;
  logic                  header_now;
  logic [LeftBits-1:0]   raster_len;
  logic [DIM_BITS-1:0]   acc_next;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign acc_next = DIM_BITS'({acc_c, 3'b000}) + DIM_BITS'({acc_c, 1'b0})
                  + DIM_BITS'(b - CHR_ZERO);
  assign raster_len = LeftBits'({prod_i, 1'b0}) + LeftBits'(prod_i);

  always_comb begin
    ph_c     = phase_q;
    magic_c  = magic_q;
    acc_c    = acc_q;
    in_num_c = in_num_q;
    fields_c = fields_q;
    width_c  = width_q;
    height_c = height_q;
    maxval_c = maxval_q;
    left_c   = left_q;
    chan_c   = chan_q;
    if (item_i.start_of_file) begin
      ph_c     = PH_MAGIC;
      magic_c  = 1'b0;
      acc_c    = '0;
      in_num_c = 1'b0;
      fields_c = 2'd0;
      width_c  = '0;
      height_c = '0;
      maxval_c = '0;
      left_c   = '0;
      chan_c   = CHAN_RED;
    end
  end

  always_comb begin
    phase_d    = ph_c;
    magic_d    = magic_c;
    acc_d      = acc_c;
    in_num_d   = in_num_c;
    fields_d   = fields_c;
    width_d    = width_c;
    height_d   = height_c;
    maxval_d   = maxval_c;
    left_d     = left_c;
    chan_d     = chan_c;
    was_max    = 1'b0;
    header_now = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (ph_c)
      PH_MAGIC: begin
        if (!magic_c) begin
          magic_d = 1'b1;
        end else begin
          phase_d = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (is_digit) begin
          acc_d    = acc_next;
          in_num_d = 1'b1;
        end else begin
          if (in_num_c) begin
            if (fields_c == 2'd0) begin
              width_d  = acc_c;
              fields_d = 2'd1;
            end else if (fields_c == 2'd1) begin
              height_d = acc_c;
              fields_d = 2'd2;
            end else begin
              maxval_d = acc_c;
              was_max  = 1'b1;
            end
            acc_d    = '0;
            in_num_d = 1'b0;
          end
          if (was_max) begin
            if (b == CHR_NEWLINE) begin
              header_now = 1'b1;
            end else begin
              phase_d = PH_TAIL;
            end
          end else if (b == CHR_HASH) begin
            phase_d = PH_COMMENT;
          end
        end
      end
      PH_COMMENT: begin
        if (b == CHR_NEWLINE) begin
          phase_d = PH_HEADER;
        end
      end
      PH_TAIL: begin
        if (b == CHR_NEWLINE) begin
          header_now = 1'b1;
        end
      end
      PH_RASTER: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_RASTER;
        res_o.pixel_byte = b;
        res_o.channel    = chan_c;
        res_o.last       = (left_c == LeftBits'(1));
        left_d           = left_c - LeftBits'(1);
        chan_d           = (chan_c >= CHAN_BLUE) ? CHAN_RED : chan_c + 2'd1;
        if (left_d == '0) begin
          phase_d = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    if (header_now) begin
      left_d             = raster_len;
      chan_d             = CHAN_RED;
      phase_d            = (prod_i == '0) ? PH_DONE : PH_RASTER;
      res_valid_o        = 1'b1;
      res_o              = '0;
      res_o.kind         = KIND_HEADER;
      res_o.image_width  = 16'(width_d);
      res_o.image_height = 16'(height_d);
      res_o.max_level    = 16'(maxval_d);
      res_o.last         = (prod_i == '0);
    end

    if (item_i.end_of_file && (phase_d != PH_DONE)) begin
      res_valid_o        = 1'b1;
      res_o              = '0;
      res_o.kind         = KIND_TRUNCATED;
      res_o.image_width  = 16'(width_d);
      res_o.image_height = 16'(height_d);
      res_o.max_level    = 16'(maxval_d);
      res_o.last         = 1'b1;
      phase_d            = PH_DONE;
    end

    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      magic_q  <= 1'b0;
      acc_q    <= '0;
      in_num_q <= 1'b0;
      fields_q <= 2'd0;
      width_q  <= '0;
      height_q <= '0;
      maxval_q <= '0;
      left_q   <= '0;
      chan_q   <= CHAN_RED;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      magic_q  <= magic_d;
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
      fields_q <= fields_d;
      width_q  <= width_d;
      height_q <= height_d;
      maxval_q <= maxval_d;
      left_q   <= left_d;
      chan_q   <= chan_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

  // The raster phase always has at least one byte still to come.
  a_raster_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RASTER) |-> (left_q != '0))
    else $error("raster phase with no bytes left");

  // A truncated result always closes the image.
  a_trunc_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KIND_TRUNCATED)) |-> res_o.last)
    else $error("truncated result without last mark");

  // Once the last result of an image has gone, only a new file restarts work.
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> (phase_q == PH_DONE))
    else $error("parser not done after last result");

endmodule

// ----- rtl/core/pps_out_buf.sv -----
// Two-entry result buffer: an output register with a skid entry behind it.
// Depends on pps_pkg for the result item type.
module pps_out_buf
  import pps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_item_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_item_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  // The skid entry is only ever filled behind a waiting output entry.
  a_skid_behind_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry holds an item while the output entry is empty");

  // No result arrives while both entries are occupied.
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");

endmodule
